FILE: hw/rtl/bme_pkg.sv
// shared codes, register indexes and kernel shape function for the morphology block
`default_nettype none

package bme_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_KSIZE  = 3'd1;
  localparam logic [2:0] REG_WIDTH  = 3'd2;
  localparam logic [2:0] REG_HEIGHT = 3'd3;

  // item kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // operation codes
  localparam logic MODE_DILATE = 1'b0;
  localparam logic MODE_ERODE  = 1'b1;

  // set value of a mask byte
  localparam logic [7:0] PIX_SET = 8'hFF;

  // ellipse membership for tap d columns and j rows back from the newest sample
  function automatic logic ell_bit(input int k, input int d, input int j);
    int a;
    int b;
    a = 2 * k - 2 * d - 1;
    b = 2 * k - 2 * j - 1;
    return (d <= 2 * k) && (j <= 2 * k) && (a * a + b * b <= 4 * (k + 1) * (k + 1));
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/binary_morphology_ellipse.sv
// streaming binary dilation and erosion with an elliptical kernel
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------
//  in      | sink      | in_valid / in_stall   | kind, pixel
//  out     | source    | out_valid / out_stall | mask_out, frame_last
//  cfg     | sink      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one item per cycle sustained while out_stall stays low; a result leaves through the
// column store read, window shift, column reduce and output register.
// the column store is read and written once per item, forwarded for back-to-back hits.
// a frame with fewer pixels than the fill latency holds in_stall after its last pixel
// while blank positions shift in, one per missing position.
// rst clears counters and pipeline valids; out_stall backs up through the pipeline.
`default_nettype none

module binary_morphology_ellipse
  import bme_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096,
  parameter int MAX_KERNEL = 33
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        kind,
  input  wire logic [7:0]  pixel,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             mask_out,
  output logic             frame_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [12:0] cfg_data
);

  localparam int KTOP  = (MAX_KERNEL % 2 == 1) ? MAX_KERNEL : MAX_KERNEL - 1;
  localparam int KHALF = KTOP / 2;
  localparam int KB    = $clog2(KHALF + 1);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int HW    = $clog2(MAX_HEIGHT);
  localparam int VRW   = $clog2(MAX_HEIGHT + KTOP + 1);
  localparam int LB    = $clog2(KHALF * MAX_WIDTH + KHALF + 1);
  localparam int MW    = KTOP - 1;

  // configuration registers
  logic        mode;
  logic [5:0]  ksize;
  logic [10:0] img_w;
  logic [12:0] img_h;

  logic          cfg_wr;
  logic          cfg_hit;
  logic [CW:0]   w_eff;
  logic [HW:0]   h_eff;
  logic [5:0]    ks_odd;
  logic [KB-1:0] k_eff;
  logic [LB-1:0] lat;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign cfg_hit   = cfg_wr && (cfg_index == REG_MODE || cfg_index == REG_KSIZE ||
                                cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_DILATE;
      ksize <= 6'd3;
      img_w <= 11'd512;
      img_h <= 13'd512;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_MODE:   mode  <= cfg_data[0];
        REG_KSIZE:  ksize <= cfg_data[5:0];
        REG_WIDTH:  img_w <= cfg_data[10:0];
        REG_HEIGHT: img_h <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // effective sizes
  always_comb begin
    if (img_w == 11'd0) w_eff = (CW + 1)'(1);
    else if (32'(img_w) > MAX_WIDTH) w_eff = (CW + 1)'(MAX_WIDTH);
    else w_eff = (CW + 1)'(img_w);
    if (img_h == 13'd0) h_eff = (HW + 1)'(1);
    else if (32'(img_h) > MAX_HEIGHT) h_eff = (HW + 1)'(MAX_HEIGHT);
    else h_eff = (HW + 1)'(img_h);
    ks_odd = ksize | 6'd1;
    if (32'(ks_odd) > KTOP) k_eff = KB'(KHALF);
    else k_eff = KB'(ks_odd >> 1);
    lat = LB'(32'(k_eff) * 32'(w_eff) + 32'(k_eff));
  end

  // frame counters
  logic [CW-1:0]  in_col;
  logic [VRW-1:0] in_row;
  logic [CW-1:0]  out_col;
  logic [HW-1:0]  out_row;
  logic [LB-1:0]  cnt;
  logic           done;

  // pipeline control
  logic go1;
  logic go2;
  logic go3;
  logic out_free;
  logic acc;
  logic pump;
  logic adv;
  logic emitting;
  logic pix_bit;
  logic last_pix;
  logic final_out;

  // blank positions shift in on their own until the window reaches the latency
  assign pump      = done && (cnt != lat);
  assign acc       = in_valid && !in_stall;
  assign adv       = (acc && (done || kind == KIND_PIXEL)) || (pump && go1);
  assign emitting  = adv && (cnt == lat);
  assign pix_bit   = (kind == KIND_PIXEL) && !done && (pixel == PIX_SET);
  assign last_pix  = (32'(in_col) == 32'(w_eff) - 1) && (32'(in_row) == 32'(h_eff) - 1);
  assign final_out = (32'(out_col) == 32'(w_eff) - 1) && (32'(out_row) == 32'(h_eff) - 1);

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
      cnt     <= '0;
      done    <= 1'b0;
    end else if (adv) begin
      if (emitting && final_out) begin
        in_col  <= '0;
        in_row  <= '0;
        out_col <= '0;
        out_row <= '0;
        cnt     <= '0;
        done    <= 1'b0;
      end else begin
        if (32'(in_col) == 32'(w_eff) - 1) begin
          in_col <= '0;
          in_row <= in_row + 1'b1;
        end else begin
          in_col <= in_col + 1'b1;
        end
        if (!done && last_pix) done <= 1'b1;
        if (cnt != lat) cnt <= cnt + 1'b1;
        if (emitting) begin
          if (32'(out_col) == 32'(w_eff) - 1) begin
            out_col <= '0;
            out_row <= out_row + 1'b1;
          end else begin
            out_col <= out_col + 1'b1;
          end
        end
      end
    end
  end

  // stage 1: column store read
  logic          p1_valid;
  logic          p1_emit;
  logic          p1_last;
  logic          p1_bit;
  logic [CW-1:0] p1_addr;
  logic [CW-1:0] p1_ox;
  logic [HW-1:0] p1_oy;
  logic          fwd_hit;
  logic [MW-1:0] fwd_data;
  logic [MW-1:0] rd_q;
  logic [MW-1:0] col_old;
  logic [MW-1:0] wr_data;
  logic [KTOP-1:0] col_vec;
  logic          p1_wr;

  logic [MW-1:0] row_store [MAX_WIDTH];

  assign col_old = fwd_hit ? fwd_data : rd_q;
  assign col_vec = {col_old, p1_bit};
  assign wr_data = col_vec[MW-1:0];
  assign p1_wr   = p1_valid && go2;

  // column store: read at accept, write back when the item leaves stage 1
  always_ff @(posedge clk) begin
    if (p1_wr) row_store[p1_addr] <= wr_data;
    if (adv) rd_q <= row_store[in_col];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (go1) begin
      p1_valid <= adv;
    end
    if (adv) begin
      p1_emit  <= emitting;
      p1_last  <= emitting && final_out;
      p1_bit   <= pix_bit;
      p1_addr  <= in_col;
      p1_ox    <= out_col;
      p1_oy    <= out_row;
      fwd_hit  <= p1_wr && (p1_addr == in_col);
      fwd_data <= wr_data;
    end
  end

  // stage 2: sliding window of column vectors
  logic            p2_valid;
  logic            p2_emit;
  logic            p2_last;
  logic [CW-1:0]   p2_ox;
  logic [HW-1:0]   p2_oy;
  logic [KTOP-1:0] win   [KTOP];
  logic [KTOP-1:0] kmask [KTOP];
  logic [KTOP-1:0] row_ok;
  logic [KTOP-1:0] col_ok;
  logic [KTOP-1:0] part;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else if (go2) begin
      p2_valid <= p1_valid;
    end
    if (p1_wr) begin
      p2_emit <= p1_emit;
      p2_last <= p1_last;
      p2_ox   <= p1_ox;
      p2_oy   <= p1_oy;
      win[0]  <= col_vec;
      for (int d = 1; d < KTOP; d++) begin
        win[d] <= win[d-1];
      end
    end
  end

  // kernel shape for the current size
  always_ff @(posedge clk) begin
    for (int d = 0; d < KTOP; d++) begin
      for (int j = 0; j < KTOP; j++) begin
        kmask[d][j] <= ell_bit(int'(k_eff), d, j);
      end
    end
  end

  // in-image masks and per-column reduction
  always_comb begin
    int iy;
    int ix;
    logic [KTOP-1:0] m;
    for (int j = 0; j < KTOP; j++) begin
      iy = int'(p2_oy) + int'(k_eff) - j;
      row_ok[j] = (iy >= 0) && (iy < int'(h_eff));
    end
    for (int d = 0; d < KTOP; d++) begin
      ix = int'(p2_ox) + int'(k_eff) - d;
      col_ok[d] = (ix >= 0) && (ix < int'(w_eff));
      m = kmask[d] & row_ok & {KTOP{col_ok[d]}};
      if (mode == MODE_ERODE) part[d] = &(~m | win[d]);
      else part[d] = |(m & win[d]);
    end
  end

  // stage 3: final reduction
  logic            p3_valid;
  logic            p3_emit;
  logic            p3_last;
  logic [KTOP-1:0] p3_part;
  logic            result;

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_valid <= 1'b0;
    end else if (go3) begin
      p3_valid <= p2_valid;
    end
    if (go3 && p2_valid) begin
      p3_emit <= p2_emit;
      p3_last <= p2_last;
      p3_part <= part;
    end
  end

  assign result = (mode == MODE_ERODE) ? &p3_part : |p3_part;

  // flow control, output register first
  assign out_free = !out_valid || !out_stall;
  assign go3      = !p3_valid || !p3_emit || out_free;
  assign go2      = !p2_valid || go3;
  assign go1      = !p1_valid || go2;
  assign in_stall = !go1 || pump;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= p3_valid && p3_emit;
    end
    if (out_free && p3_valid && p3_emit) begin
      mask_out   <= result;
      frame_last <= p3_last;
    end
  end

  // the fill count never passes the latency
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= lat)
    else $error("fill count above latency");

  // a result waiting on a blocked output stays in stage 3
  a_p3_hold: assert property (@(posedge clk) disable iff (rst)
    p3_valid && p3_emit && !out_free |=> p3_valid && p3_emit)
    else $error("result lost in stage 3");

  // the final result of a frame restarts every counter
  a_restart: assert property (@(posedge clk) disable iff (rst)
    adv && emitting && final_out && !cfg_hit |=>
      in_col == '0 && in_row == '0 && out_col == '0 && out_row == '0 && !done)
    else $error("frame did not restart");

  // forwarding only pairs with a live stage 1 item
  a_fwd: assert property (@(posedge clk) disable iff (rst)
    go1 && adv && p1_wr && p1_addr == in_col |=> fwd_hit && p1_valid)
    else $error("missed column forward");

endmodule

`default_nettype wire

FILE: verif/tb_binary_morphology_ellipse.sv
// testbench for the streaming elliptical-kernel dilation and erosion block
`default_nettype none

// scoreboard: tracks the frame, predicts each result and checks the output stream
class morph_scoreboard;
  typedef struct packed {
    logic mask;
    logic last;
  } mask_result_t;

  mask_result_t expected_pixels[$];
  bit           line_bits[66][1024];
  int unsigned  op_mode;
  int unsigned  ksize;
  int unsigned  width_reg;
  int unsigned  height_reg;
  int unsigned  in_col;
  int unsigned  in_row;
  int unsigned  out_col;
  int unsigned  out_row;
  bit           in_done;
  int           errors;

  function new();
    op_mode    = bme_pkg::MODE_DILATE;
    ksize      = 3;
    width_reg  = 512;
    height_reg = 512;
    errors     = 0;
    restart();
  endfunction

  function void restart();
    in_col  = 0;
    in_row  = 0;
    out_col = 0;
    out_row = 0;
    in_done = 0;
  endfunction

  function int unsigned eff_w();
    if (width_reg < 1) return 1;
    if (width_reg > 1024) return 1024;
    return width_reg;
  endfunction

  function int unsigned eff_h();
    if (height_reg < 1) return 1;
    if (height_reg > 4096) return 4096;
    return height_reg;
  endfunction

  function int unsigned eff_half();
    int unsigned sz;
    sz = ksize | 1;
    if (sz > 33) sz = 33;
    return sz / 2;
  endfunction

  // register write restarts the frame; indexes past the list are ignored
  function void write_reg(logic [2:0] idx, logic [12:0] data);
    case (idx)
      bme_pkg::REG_MODE: begin
        op_mode = data[0];
      end
      bme_pkg::REG_KSIZE: begin
        ksize = data[5:0];
      end
      bme_pkg::REG_WIDTH: begin
        width_reg = data[10:0];
      end
      bme_pkg::REG_HEIGHT: begin
        height_reg = data;
      end
      default: begin
        return;
      end
    endcase
    restart();
  endfunction

  // results still owed to the current frame once its input is complete
  function int unsigned owed();
    if (!in_done) return 0;
    return eff_w() * eff_h() - (out_row * eff_w() + out_col);
  endfunction

  // reduce the kernel window around the next output pixel
  function void predict_pixel();
    int k;
    int w;
    int h;
    int r2;
    int iy;
    int ix;
    int a;
    int b;
    bit erode;
    bit res;
    mask_result_t r;
    k = eff_half();
    w = eff_w();
    h = eff_h();
    r2 = 4 * (k + 1) * (k + 1);
    erode = (op_mode == bme_pkg::MODE_ERODE);
    res = erode;
    for (int ky = 0; ky <= 2 * k; ky++) begin
      iy = int'(out_row) + ky - k;
      b = 2 * ky - 2 * k - 1;
      if (iy < 0 || iy >= h) continue;
      for (int kx = 0; kx <= 2 * k; kx++) begin
        ix = int'(out_col) + kx - k;
        a = 2 * kx - 2 * k - 1;
        if (a * a + b * b > r2) continue;
        if (ix < 0 || ix >= w) continue;
        if (erode && !line_bits[iy % 66][ix]) res = 0;
        if (!erode && line_bits[iy % 66][ix]) res = 1;
      end
    end
    r.mask = res;
    r.last = 1'b0;
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
      if (out_row >= h) begin
        r.last = 1'b1;
        restart();
      end
    end
    expected_pixels.insert(expected_pixels.size(), r);
  endfunction

  // accepted request: store the pixel and predict any result it releases
  function void note_request(logic kd, logic [7:0] pix);
    int unsigned w;
    int unsigned h;
    int unsigned total;
    int unsigned lat;
    int unsigned in_lin;
    int unsigned out_lin;
    w = eff_w();
    h = eff_h();
    total = w * h;
    lat = eff_half() * w + eff_half();
    if (kd == bme_pkg::KIND_PIXEL && !in_done) begin
      line_bits[in_row % 66][in_col] = (pix == bme_pkg::PIX_SET);
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
        if (in_row >= h) begin
          in_row = 0;
          in_done = 1;
        end
      end
      in_lin = in_done ? total : in_row * w + in_col;
      out_lin = out_row * w + out_col;
      if (in_lin - out_lin > lat) predict_pixel();
      return;
    end
    // flush ticks, and pixels while draining
    if (in_done && out_row * w + out_col < total) predict_pixel();
  endfunction

  function void check_result(logic m, logic l);
    mask_result_t r;
    if (expected_pixels.size() == 0) begin
      if (errors < 10) $display("unexpected result mask_out=%0d frame_last=%0d", m, l);
      errors++;
      return;
    end
    r = expected_pixels.pop_front();
    if (r.mask !== m || r.last !== l) begin
      if (errors < 10) begin
        $display("mismatch: expected mask_out=%0d frame_last=%0d, got %0d %0d",
                 r.mask, r.last, m, l);
      end
      errors++;
    end
  endfunction
endclass

module tb_binary_morphology_ellipse
  import bme_pkg::*;
;

  localparam int CYCLE_LIMIT = 3000000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        kind;
  logic [7:0]  pixel;
  logic        out_valid;
  logic        out_stall;
  logic        mask_out;
  logic        frame_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [12:0] cfg_data;

  morph_scoreboard sb = new();
  int  cycles = 0;
  int  rand_items = 0;
  bit  quiet = 0;
  bit  hold_req = 0;

  binary_morphology_ellipse i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .pixel     (pixel),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .mask_out  (mask_out),
    .frame_last(frame_last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** binary_morphology_ellipse: FAILED **");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(mask_out, frame_last);
  end

  // receiver stall: random bursts, one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (300) @(negedge clk);
        hold_req = 0;
        out_stall = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 11)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  task automatic send_item(input logic kd, input logic [7:0] pix);
    int gap;
    if (!quiet && $urandom_range(0, 15) == 0) begin
      in_valid = 1'b0;
      gap = $urandom_range(1, 11);
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    kind = kd;
    pixel = pix;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(kd, pix);
    rand_items++;
    @(negedge clk);
  endtask

  task automatic write_cfg(input logic [2:0] idx, input logic [12:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // wait for every expected result, then let the pipeline empty
  task automatic wait_idle();
    in_valid = 1'b0;
    while (sb.expected_pixels.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  function automatic logic [7:0] mask_byte(int set_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < set_pct) return PIX_SET;
    if (r < set_pct + (100 - set_pct) / 2) return 8'd0;
    return 8'($urandom);
  endfunction

  task automatic set_frame(int mode, int ks, int w, int h);
    write_cfg(REG_MODE, {12'($urandom), 1'(mode)});
    write_cfg(REG_KSIZE, {7'($urandom), 6'(ks)});
    write_cfg(REG_WIDTH, {2'($urandom), 11'(w)});
    write_cfg(REG_HEIGHT, 13'(h));
    if ($urandom_range(0, 3) == 0) write_cfg(REG_HEIGHT + 3'($urandom_range(1, 4)), 13'($urandom));
  endtask

  // one frame of pixels with some early flushes, then drain; abort < 0 means full frame
  task automatic run_frame(int set_pct, int abort);
    int n;
    n = sb.eff_w() * sb.eff_h();
    for (int i = 0; i < n; i++) begin
      if (i == abort) break;
      if ($urandom_range(0, 19) == 0) send_item(KIND_FLUSH, 8'($urandom));
      send_item(KIND_PIXEL, mask_byte(set_pct));
    end
    if (abort < 0) begin
      while (sb.owed() > 0) begin
        if ($urandom_range(0, 7) == 0) send_item(KIND_PIXEL, mask_byte(set_pct));
        else send_item(KIND_FLUSH, 8'($urandom));
      end
      if ($urandom_range(0, 1) == 0) send_item(KIND_FLUSH, 8'($urandom));
    end
    wait_idle();
  endtask

  initial begin
    logic [7:0] dir_pix[12];
    int ks;
    int mode;
    dir_pix = '{8'hFF, 8'hFE, 8'h00, 8'h01, 8'h80, 8'hFF,
                8'h7F, 8'hFF, 8'h00, 8'hFF, 8'h40, 8'hFF};
    rst = 1'b1;
    in_valid = 1'b0;
    kind = KIND_PIXEL;
    pixel = 8'd0;
    cfg_valid = 1'b0;
    cfg_index = REG_MODE;
    cfg_data = 13'd0;
    repeat (11) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // directed: early flush, near-set bytes, pixel while draining, flush past the end
    set_frame(MODE_DILATE, 3, 4, 3);
    send_item(KIND_FLUSH, 8'hFF);
    foreach (dir_pix[i]) send_item(KIND_PIXEL, dir_pix[i]);
    send_item(KIND_PIXEL, PIX_SET);
    while (sb.owed() > 0) send_item(KIND_FLUSH, 8'h00);
    send_item(KIND_FLUSH, 8'h00);
    wait_idle();

    // extremes: oversized kernel, capped width and height, zero sizes; large frames cut short
    set_frame(MODE_DILATE, 63, 40, 2);
    run_frame(3, -1);
    set_frame(MODE_ERODE, 0, 2047, 1);
    run_frame(50, 300);
    set_frame(MODE_ERODE, 5, 1, 8191);
    run_frame(90, 200);
    set_frame(MODE_ERODE, 0, 0, 0);
    run_frame(50, -1);
    set_frame(MODE_DILATE, 33, 20, 3);
    run_frame(2, -1);

    // long receiver hold-off with one result per pixel
    set_frame(MODE_ERODE, 1, 16, 16);
    hold_req = 1;
    run_frame(70, -1);

    // random frames, the last stretch without idling
    rand_items = 0;
    while (rand_items < 750) begin
      quiet = (rand_items > 600);
      mode = $urandom_range(0, 1);
      ks = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 7);
      set_frame(mode, ks, $urandom_range(1, 24), $urandom_range(1, 10));
      run_frame(mode == MODE_ERODE ? 80 : 15,
                ($urandom_range(0, 5) == 0) ? $urandom_range(0, 40) : -1);
    end

    wait_idle();
    if (sb.errors == 0 && sb.expected_pixels.size() == 0) begin
      $display("** binary_morphology_ellipse: PASSED **");
    end else begin
      $display("** binary_morphology_ellipse: FAILED **");
    end
    $finish;
  end
endmodule

`default_nettype wire
